// ===== src/lfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfc_pkg
// Types and constants shared by the framed log checker: beat structs,
// parser phase, result codes, frame magic and FNV-1a constants.
// ----------------------------------------------------------------------------
package lfc_pkg;

  // Frame format
  localparam logic [31:0] LOG_MAGIC  = 32'h314C_4157;
  localparam logic [4:0]  HEADER_LEN = 5'd17;

  // Header byte positions (count of header bytes already taken)
  localparam logic [4:0]  HDR_ROW_START  = 5'd4;
  localparam logic [4:0]  HDR_KIND_POS   = 5'd8;
  localparam logic [4:0]  HDR_LEN_START  = 5'd9;
  localparam logic [4:0]  HDR_SUM_START  = 5'd13;

  // Frame kind byte value that marks a row deletion
  localparam logic [7:0]  KIND_TOMBSTONE = 8'd1;

  // FNV-1a, 32 bit
  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  // Result codes
  localparam logic [2:0] RK_BYTE     = 3'd0;
  localparam logic [2:0] RK_EMPTY    = 3'd1;
  localparam logic [2:0] RK_BADMAGIC = 3'd2;
  localparam logic [2:0] RK_TRUNC    = 3'd3;
  localparam logic [2:0] RK_CLEAN    = 3'd4;

  // Parser phase
  typedef enum logic [0:0] {
    PH_HEADER  = 1'b0,
    PH_PAYLOAD = 1'b1
  } phase_t;

  // Input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_log;
  } lfc_in_t;

  // Result beat
  typedef struct packed {
    logic [2:0]  result_kind;
    logic [7:0]  out_byte;
    logic [31:0] row_index;
    logic        is_tombstone;
    logic [31:0] payload_length;
    logic        last_in_frame;
    logic        checksum_good;
  } lfc_out_t;

endpackage

// ===== src/log_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_frame_checker
// Splits a log byte stream into frames (17-byte header, then payload),
// passes payload bytes through with header info and checks FNV-1a hashes.
// ----------------------------------------------------------------------------
// Results: each accepted input beat's result is captured in the output
//   register.
// Throughput: 1 byte per cycle when not stalled; the FNV-1a step (xor,
//   constant multiply) runs once per payload byte on the hash register.
// Reset: synchronous, active low; parser returns to the header phase, hash to
//   the FNV offset basis, halt flag and output valid cleared.
module log_frame_checker
  import lfc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  lfc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output lfc_out_t out_data
);

  // Parser state
  phase_t      phase_r,        phase_nxt;
  logic [4:0]  header_count_r, header_count_nxt;
  logic [31:0] magic_r,        magic_nxt;
  logic [31:0] row_r,          row_nxt;
  logic [7:0]  kind_r,         kind_nxt;
  logic [31:0] length_r,       length_nxt;
  logic [31:0] sum_r,          sum_nxt;
  logic [31:0] bytes_left_r,   bytes_left_nxt;
  logic [31:0] hash_r,         hash_nxt;
  logic        halted_r,       halted_nxt;

  // Output register
  logic        out_valid_r;
  lfc_out_t    out_data_r;

  // Result of this cycle's beat
  logic        res_valid;
  lfc_out_t    res;

  logic        in_fire;
  logic [7:0]  b;
  logic [31:0] hash_step;
  logic [31:0] left_dec;
  logic [4:0]  hc;
  logic [4:0]  hc_inc;

  // Output register frees up when empty or when its beat is taken
  assign in_stall  = out_valid_r && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign b         = in_data.data_byte;
  assign hash_step = (hash_r ^ {24'd0, b}) * HASH_PRIME;
  assign left_dec  = bytes_left_r - 32'd1;
  assign hc        = (header_count_r >= HEADER_LEN) ? 5'd0 : header_count_r;
  assign hc_inc    = hc + 5'd1;

  // Next state and result
  always_comb begin
    phase_nxt        = phase_r;
    header_count_nxt = header_count_r;
    magic_nxt        = magic_r;
    row_nxt          = row_r;
    kind_nxt         = kind_r;
    length_nxt       = length_r;
    sum_nxt          = sum_r;
    bytes_left_nxt   = bytes_left_r;
    hash_nxt         = hash_r;
    halted_nxt       = halted_r;
    res_valid        = 1'b0;
    res              = '0;

    if (in_fire && !halted_r) begin
      if (in_data.end_of_log) begin
        // end of log: clean only between frames
        res_valid       = 1'b1;
        res.result_kind = (phase_r == PH_HEADER && header_count_r == 5'd0) ?
                          RK_CLEAN : RK_TRUNC;
        halted_nxt      = 1'b1;
      end else if (phase_r == PH_PAYLOAD && bytes_left_r != 32'd0) begin
        // payload byte
        hash_nxt           = hash_step;
        bytes_left_nxt     = left_dec;
        res_valid          = 1'b1;
        res.result_kind    = RK_BYTE;
        res.out_byte       = b;
        res.row_index      = row_r;
        res.is_tombstone   = (kind_r == KIND_TOMBSTONE);
        res.payload_length = length_r;
        if (left_dec == 32'd0) begin
          res.last_in_frame = 1'b1;
          res.checksum_good = (hash_step == sum_r);
          phase_nxt         = PH_HEADER;
          header_count_nxt  = 5'd0;
          if (hash_step != sum_r) begin
            halted_nxt = 1'b1;
          end
        end
      end else begin
        // header byte, little-endian fields shift in from the top
        phase_nxt        = PH_HEADER;
        header_count_nxt = hc_inc;
        if (hc < HDR_ROW_START) begin
          magic_nxt = {b, magic_r[31:8]};
        end else if (hc < HDR_KIND_POS) begin
          row_nxt = {b, row_r[31:8]};
        end else if (hc == HDR_KIND_POS) begin
          kind_nxt = b;
        end else if (hc < HDR_SUM_START) begin
          length_nxt = {b, length_r[31:8]};
        end else begin
          sum_nxt = {b, sum_r[31:8]};
        end

        if (hc_inc == HDR_ROW_START && magic_nxt != LOG_MAGIC) begin
          res_valid       = 1'b1;
          res.result_kind = RK_BADMAGIC;
          halted_nxt      = 1'b1;
        end else if (hc_inc == HEADER_LEN) begin
          header_count_nxt = 5'd0;
          if (length_nxt == 32'd0) begin
            // empty payload, accepted without a check
            res_valid          = 1'b1;
            res.result_kind    = RK_EMPTY;
            res.row_index      = row_nxt;
            res.is_tombstone   = (kind_nxt == KIND_TOMBSTONE);
            res.payload_length = length_nxt;
          end else begin
            phase_nxt      = PH_PAYLOAD;
            bytes_left_nxt = length_nxt;
            hash_nxt       = HASH_BASIS;
          end
        end
      end
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      header_count_r <= 5'd0;
      magic_r        <= 32'd0;
      row_r          <= 32'd0;
      kind_r         <= 8'd0;
      length_r       <= 32'd0;
      sum_r          <= 32'd0;
      bytes_left_r   <= 32'd0;
      hash_r         <= HASH_BASIS;
      halted_r       <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      header_count_r <= header_count_nxt;
      magic_r        <= magic_nxt;
      row_r          <= row_nxt;
      kind_r         <= kind_nxt;
      length_r       <= length_nxt;
      sum_r          <= sum_nxt;
      bytes_left_r   <= bytes_left_nxt;
      hash_r         <= hash_nxt;
      halted_r       <= halted_nxt;
    end
  end

  // Output register, held while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_data_r <= res;
    end
  end

  // Once halted, only reset restarts the parser
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag cleared without reset");

  // Payload phase always has bytes still to come
  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (bytes_left_r != 32'd0))
    else $error("payload phase with no bytes left");

  // Terminal results leave the parser halted
  a_term_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.result_kind == RK_BADMAGIC ||
                     out_data_r.result_kind == RK_TRUNC ||
                     out_data_r.result_kind == RK_CLEAN)) |-> halted_r)
    else $error("terminal result without halt");

  // Checksum verdict only rides on a frame's last payload byte
  a_good_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.checksum_good) |->
      (out_data_r.last_in_frame && out_data_r.result_kind == RK_BYTE))
    else $error("checksum flag outside last payload byte");

endmodule
